@@ rtl/core/trilinear_grid_interpolator_macros.svh @@
// ============================================================================
// Trilinear grid interpolator assertion macros
// Shared macros for the concurrent checks on the interpolator's ports.
// ============================================================================
`ifndef TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tgi_pkg.sv @@
// ============================================================================
// Trilinear grid interpolator package
// Grid geometry, field widths, operation codes and shared types.
// ============================================================================
package tgi_pkg;

    // Grid geometry and coordinate format.
    localparam int ROWS      = 64;
    localparam int COLS      = 64;
    localparam int SLICES    = 32;
    localparam int FRAC_BITS = 8;

    // Field widths fixed by the request format.
    localparam int ADDR_W     = 17;
    localparam int VAL_W      = 24;
    localparam int COORD_IJ_W = 14;
    localparam int COORD_K_W  = 13;

    // Derived widths.
    localparam int ROW_IDX_W   = $clog2(ROWS);
    localparam int COL_IDX_W   = $clog2(COLS);
    localparam int SLICE_IDX_W = $clog2(SLICES);
    localparam int IP_IJ_W     = COORD_IJ_W - FRAC_BITS;
    localparam int KP_W        = COORD_K_W - FRAC_BITS;
    localparam int W_W         = FRAC_BITS + 1;
    localparam int X_W         = VAL_W + 2 * FRAC_BITS;
    localparam int ACC_W       = VAL_W + 3 * FRAC_BITS + 2;

    // Request actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Integer slice index reduced modulo the slice count.
    typedef logic [2**KP_W-1:0][SLICE_IDX_W-1:0] t_kmod_tab;

    function automatic t_kmod_tab build_kmod();
        t_kmod_tab                tab;
        logic [SLICE_IDX_W-1:0]   m;
        m = '0;
        for (int n = 0; n < 2**KP_W; n++) begin
            tab[n[KP_W-1:0]] = m;
            m = (int'(m) == SLICES - 1) ? '0 : m + 1'b1;
        end
        return tab;
    endfunction

    localparam t_kmod_tab KMOD_TAB = build_kmod();

    // Interpolation weights of the three axes.
    typedef struct packed {
        logic [W_W-1:0] wi_lo;
        logic [W_W-1:0] wi_hi;
        logic [W_W-1:0] wj_lo;
        logic [W_W-1:0] wj_hi;
        logic [W_W-1:0] wk_lo;
        logic [W_W-1:0] wk_hi;
    } t_weights;

    // Control of the coordinate unit.
    typedef struct packed {
        logic       decode;
        logic       base;
        logic [2:0] sel;
    } t_coord_ctl;

    // One operation of the shared multiply-accumulate unit.
    typedef struct packed {
        logic                  en;
        logic                  clear;
        logic [W_W-1:0]        weight;
        logic signed [X_W-1:0] operand;
    } t_mac_op;

endpackage

@@ rtl/core/tgi_if.sv @@
// ============================================================================
// Trilinear grid interpolator channels
// Request and response channels with a valid/ready handshake.
// ============================================================================
interface tgi_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      action;
    logic [tgi_pkg::ADDR_W-1:0]                load_addr;
    logic signed [tgi_pkg::VAL_W-1:0]          load_value;
    logic [tgi_pkg::COORD_IJ_W-1:0]            coord_i;
    logic [tgi_pkg::COORD_IJ_W-1:0]            coord_j;
    logic [tgi_pkg::COORD_K_W-1:0]             coord_k;

    modport source (
        output valid, action, load_addr, load_value, coord_i, coord_j, coord_k,
        input  ready
    );
    modport sink (
        input  valid, action, load_addr, load_value, coord_i, coord_j, coord_k,
        output ready
    );
endinterface

interface tgi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tgi_pkg::VAL_W-1:0]  interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink   (input valid, interp_value, output ready);
endinterface

@@ rtl/core/tgi_grid_ram.sv @@
// ============================================================================
// Grid sample memory
// Single-port RAM with a registered read port.
// ============================================================================
module tgi_grid_ram #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // One access per cycle: a registered read, plus a write when enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tgi_coord.sv @@
// ============================================================================
// Coordinate unit
// Splits the query coordinates into neighbour indices and weights, and
// forms the memory address of each of the eight neighbours.
// ============================================================================
module tgi_coord (
    input  logic                                 i_clk,
    input  tgi_pkg::t_coord_ctl                  i_ctl,
    input  logic [tgi_pkg::COORD_IJ_W-1:0]       i_coord_i,
    input  logic [tgi_pkg::COORD_IJ_W-1:0]       i_coord_j,
    input  logic [tgi_pkg::COORD_K_W-1:0]        i_coord_k,
    output logic [tgi_pkg::ADDR_W-1:0]           o_addr,
    output tgi_pkg::t_weights                    o_weights
);

    localparam int F      = tgi_pkg::FRAC_BITS;
    localparam int AW     = tgi_pkg::ADDR_W;
    localparam int PLANE  = tgi_pkg::ROWS * tgi_pkg::COLS;

    logic [tgi_pkg::IP_IJ_W-1:0]     ip_i;
    logic [tgi_pkg::IP_IJ_W-1:0]     ip_j;
    logic [tgi_pkg::KP_W-1:0]        kp;
    logic [F-1:0]                    fr_i;
    logic [F-1:0]                    fr_j;
    logic [F-1:0]                    fr_k;
    logic [tgi_pkg::ROW_IDX_W-1:0]   n_i_lo, n_i_hi;
    logic [tgi_pkg::COL_IDX_W-1:0]   n_j_lo, n_j_hi;
    logic [tgi_pkg::SLICE_IDX_W-1:0] n_k_lo, n_k_hi;
    tgi_pkg::t_weights               n_wts;

    logic [tgi_pkg::ROW_IDX_W-1:0]   r_i_lo, r_i_hi;
    logic [tgi_pkg::COL_IDX_W-1:0]   r_j_lo, r_j_hi;
    logic [tgi_pkg::SLICE_IDX_W-1:0] r_k_lo, r_k_hi;
    tgi_pkg::t_weights               r_wts;
    logic [AW-1:0]                   r_kb [2];
    logic [AW-1:0]                   r_ib [2];
    logic [AW-1:0]                   r_jb [2];

    assign ip_i = i_coord_i[tgi_pkg::COORD_IJ_W-1:F];
    assign ip_j = i_coord_j[tgi_pkg::COORD_IJ_W-1:F];
    assign kp   = i_coord_k[tgi_pkg::COORD_K_W-1:F];
    assign fr_i = i_coord_i[F-1:0];
    assign fr_j = i_coord_j[F-1:0];
    assign fr_k = i_coord_k[F-1:0];

    // Row and column clamp to the last line; the slice index wraps.
    always_comb begin
        if (int'(ip_i) >= tgi_pkg::ROWS - 1) begin
            n_i_lo = tgi_pkg::ROW_IDX_W'(tgi_pkg::ROWS - 1);
            n_i_hi = tgi_pkg::ROW_IDX_W'(tgi_pkg::ROWS - 1);
        end else begin
            n_i_lo = tgi_pkg::ROW_IDX_W'(ip_i);
            n_i_hi = tgi_pkg::ROW_IDX_W'(ip_i) + tgi_pkg::ROW_IDX_W'(1);
        end
        if (int'(ip_j) >= tgi_pkg::COLS - 1) begin
            n_j_lo = tgi_pkg::COL_IDX_W'(tgi_pkg::COLS - 1);
            n_j_hi = tgi_pkg::COL_IDX_W'(tgi_pkg::COLS - 1);
        end else begin
            n_j_lo = tgi_pkg::COL_IDX_W'(ip_j);
            n_j_hi = tgi_pkg::COL_IDX_W'(ip_j) + tgi_pkg::COL_IDX_W'(1);
        end
        n_k_lo = tgi_pkg::KMOD_TAB[kp];
        n_k_hi = (int'(n_k_lo) == tgi_pkg::SLICES - 1) ? '0 : n_k_lo + 1'b1;

        n_wts.wi_hi = {1'b0, fr_i};
        n_wts.wj_hi = {1'b0, fr_j};
        n_wts.wk_hi = {1'b0, fr_k};
        n_wts.wi_lo = {1'b1, {F{1'b0}}} - {1'b0, fr_i};
        n_wts.wj_lo = {1'b1, {F{1'b0}}} - {1'b0, fr_j};
        n_wts.wk_lo = {1'b1, {F{1'b0}}} - {1'b0, fr_k};
    end

    // Indices and weights are captured when a query is taken.
    always_ff @(posedge i_clk) begin
        if (i_ctl.decode) begin
            r_i_lo <= n_i_lo;
            r_i_hi <= n_i_hi;
            r_j_lo <= n_j_lo;
            r_j_hi <= n_j_hi;
            r_k_lo <= n_k_lo;
            r_k_hi <= n_k_hi;
            r_wts  <= n_wts;
        end
    end

    // Address terms of each axis, wrapped to the memory size.
    always_ff @(posedge i_clk) begin
        if (i_ctl.base) begin
            r_kb[0] <= AW'(int'(r_k_lo) * PLANE);
            r_kb[1] <= AW'(int'(r_k_hi) * PLANE);
            r_ib[0] <= AW'(int'(r_i_lo) * tgi_pkg::COLS);
            r_ib[1] <= AW'(int'(r_i_hi) * tgi_pkg::COLS);
            r_jb[0] <= AW'(r_j_lo);
            r_jb[1] <= AW'(r_j_hi);
        end
    end

    // Neighbour select: bit 0 picks the slice, bit 1 the row, bit 2 the column.
    assign o_addr    = r_kb[i_ctl.sel[0]] + r_ib[i_ctl.sel[1]] + r_jb[i_ctl.sel[2]];
    assign o_weights = r_wts;

endmodule

@@ rtl/core/tgi_mac.sv @@
// ============================================================================
// Shared multiply-accumulate unit
// Multiplies an unsigned weight by a signed operand and adds the product to
// the accumulator, or starts a new sum.
// ============================================================================
module tgi_mac (
    input  logic                                i_clk,
    input  tgi_pkg::t_mac_op                    i_op,
    output logic signed [tgi_pkg::ACC_W-1:0]    o_acc
);

    logic signed [tgi_pkg::W_W:0]     w_s;
    logic signed [tgi_pkg::ACC_W-1:0] prod;
    logic signed [tgi_pkg::ACC_W-1:0] n_acc;
    logic signed [tgi_pkg::ACC_W-1:0] r_acc;

    // Weight is widened by a zero sign bit so the product stays exact.
    assign w_s   = $signed({1'b0, i_op.weight});
    assign prod  = w_s * i_op.operand;
    assign n_acc = (i_op.clear ? '0 : r_acc) + prod;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/trilinear_grid_interpolator.sv @@
// ============================================================================
// Trilinear grid interpolator
// Grid memory with a sequenced trilinear interpolation on a shared MAC.
// ============================================================================
// The block holds a grid of SLICES x ROWS x COLS signed samples (12 fraction
// bits) in one single-port memory. A load request writes one sample in the
// cycle it is taken. A query request with row, column and slice
// coordinates (8 fraction bits) returns one interpolated sample, rounded to
// nearest with ties upwards; rows and columns clamp at the last line and the
// slice axis wraps. A query occupies the block from the cycle it is taken:
// an address set-up step, eight memory reads through the single port, and
// fourteen multiply-accumulate steps on the one shared multiplier, which
// overlap the reads and are followed by a rounding step. The input is
// not ready while a query is in progress; a finished result waits in an output
// register while loads and the next query are taken. The memory has no reset
// and no clearing pass: queries must only touch samples that were loaded.
module trilinear_grid_interpolator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgi_in_if.sink     i_req,
    tgi_out_if.source  o_rsp
);

    localparam int F      = tgi_pkg::FRAC_BITS;
    localparam int STEP_W = 5;

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Sequencer steps.
    localparam logic [STEP_W-1:0] STEP_BASE       = 5'd0;
    localparam logic [STEP_W-1:0] STEP_READ_FIRST = 5'd1;
    localparam logic [STEP_W-1:0] STEP_KMAC_FIRST = 5'd2;
    localparam logic [STEP_W-1:0] STEP_PAIR_FIRST = 5'd4;
    localparam logic [STEP_W-1:0] STEP_KMAC_LAST  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_PAIR_LAST  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_ROW0_LO    = 5'd10;
    localparam logic [STEP_W-1:0] STEP_ROW0_HI    = 5'd11;
    localparam logic [STEP_W-1:0] STEP_ROW1_LO    = 5'd12;
    localparam logic [STEP_W-1:0] STEP_ROW1_HI    = 5'd13;
    localparam logic [STEP_W-1:0] STEP_COL_LO     = 5'd14;
    localparam logic [STEP_W-1:0] STEP_COL_HI     = 5'd15;
    localparam logic [STEP_W-1:0] STEP_ROUND      = 5'd16;

    localparam logic [tgi_pkg::ACC_W-1:0] ROUND_HALF =
        tgi_pkg::ACC_W'({1'b1, {(3 * F - 1){1'b0}}});

    logic                                r_state, n_state;
    logic [STEP_W-1:0]                   r_step, n_step;
    logic                                r_out_valid, n_out_valid;
    logic signed [tgi_pkg::VAL_W-1:0]    r_out_value;
    logic signed [tgi_pkg::X_W-1:0]      r_tmp [4];

    logic                                req_take;
    logic                                query_start;
    logic                                load_write;
    logic                                out_free;
    logic                                finish;
    logic [2:0]                          kmac_n;
    logic [1:0]                          pair_idx;
    logic [tgi_pkg::ADDR_W-1:0]          read_addr;
    logic [tgi_pkg::ADDR_W-1:0]          ram_addr;
    logic [tgi_pkg::VAL_W-1:0]           ram_rdata;
    logic signed [tgi_pkg::ACC_W-1:0]    acc;
    logic [tgi_pkg::ACC_W-1:0]           round_sum;
    tgi_pkg::t_weights                   wts;
    tgi_pkg::t_coord_ctl                 coord_ctl;
    tgi_pkg::t_mac_op                    mac_op;

    // Request handshake.
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign query_start = req_take && (i_req.action == tgi_pkg::ACT_QUERY);
    assign load_write  = req_take && (i_req.action == tgi_pkg::ACT_LOAD);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign finish      = (r_state == ST_RUN) && (r_step == STEP_ROUND) && out_free;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (query_start) begin
                    n_state = ST_RUN;
                    n_step  = STEP_BASE;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_ROUND) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_BASE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Coordinate unit: decode on query, address terms in the first step.
    assign coord_ctl.decode = query_start;
    assign coord_ctl.base   = (r_state == ST_RUN) && (r_step == STEP_BASE);
    assign coord_ctl.sel    = 3'(r_step - STEP_READ_FIRST);

    tgi_coord u_coord (
        .i_clk     (i_clk),
        .i_ctl     (coord_ctl),
        .i_coord_i (i_req.coord_i),
        .i_coord_j (i_req.coord_j),
        .i_coord_k (i_req.coord_k),
        .o_addr    (read_addr),
        .o_weights (wts)
    );

    // Grid memory: loads write in the cycle they are taken.
    assign ram_addr = load_write ? i_req.load_addr : read_addr;

    tgi_grid_ram #(
        .ADDR_W (tgi_pkg::ADDR_W),
        .DATA_W (tgi_pkg::VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load_write),
        .i_addr  (ram_addr),
        .i_wdata (i_req.load_value),
        .o_rdata (ram_rdata)
    );

    // MAC schedule: slice pairs from memory, then rows, then columns.
    assign kmac_n = 3'(r_step - STEP_KMAC_FIRST);

    always_comb begin
        mac_op.en      = 1'b0;
        mac_op.clear   = 1'b0;
        mac_op.weight  = wts.wk_lo;
        mac_op.operand = tgi_pkg::X_W'($signed(ram_rdata));
        if (r_state == ST_RUN) begin
            if (r_step inside {[STEP_KMAC_FIRST:STEP_KMAC_LAST]}) begin
                mac_op.en     = 1'b1;
                mac_op.clear  = !kmac_n[0];
                mac_op.weight = kmac_n[0] ? wts.wk_hi : wts.wk_lo;
            end else begin
                case (r_step)
                    STEP_ROW0_LO: begin
                        mac_op.en      = 1'b1;
                        mac_op.clear   = 1'b1;
                        mac_op.weight  = wts.wi_lo;
                        mac_op.operand = r_tmp[0];
                    end
                    STEP_ROW0_HI: begin
                        mac_op.en      = 1'b1;
                        mac_op.weight  = wts.wi_hi;
                        mac_op.operand = r_tmp[1];
                    end
                    STEP_ROW1_LO: begin
                        mac_op.en      = 1'b1;
                        mac_op.clear   = 1'b1;
                        mac_op.weight  = wts.wi_lo;
                        mac_op.operand = r_tmp[2];
                    end
                    STEP_ROW1_HI: begin
                        mac_op.en      = 1'b1;
                        mac_op.weight  = wts.wi_hi;
                        mac_op.operand = r_tmp[3];
                    end
                    STEP_COL_LO: begin
                        mac_op.en      = 1'b1;
                        mac_op.clear   = 1'b1;
                        mac_op.weight  = wts.wj_lo;
                        mac_op.operand = r_tmp[0];
                    end
                    STEP_COL_HI: begin
                        mac_op.en      = 1'b1;
                        mac_op.weight  = wts.wj_hi;
                        mac_op.operand = r_tmp[1];
                    end
                    default: begin
                        mac_op.en = 1'b0;
                    end
                endcase
            end
        end
    end

    tgi_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_acc (acc)
    );

    // Partial sums: each slice pair lands on an even step, then the rows.
    assign pair_idx = 2'((r_step - STEP_PAIR_FIRST) >> 1);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            if ((r_step inside {[STEP_PAIR_FIRST:STEP_PAIR_LAST]}) && !r_step[0]) begin
                r_tmp[pair_idx] <= tgi_pkg::X_W'(acc);
            end else if (r_step == STEP_ROW1_LO) begin
                r_tmp[0] <= tgi_pkg::X_W'(acc);
            end else if (r_step == STEP_COL_LO) begin
                r_tmp[1] <= tgi_pkg::X_W'(acc);
            end
        end
    end

    // Round once to nearest, ties upwards, and drop the weight fraction bits.
    assign round_sum = acc + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_value <= round_sum[3 * F +: tgi_pkg::VAL_W];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.interp_value = r_out_value;

endmodule

@@ rtl/core/tgi_checker.sv @@
// ============================================================================
// Trilinear grid interpolator checker
// Port-level checks on request and response timing, bound to the top level.
// ============================================================================
`include "trilinear_grid_interpolator_macros.svh"

module tgi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_action,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [tgi_pkg::VAL_W-1:0]  i_out_value
);

    logic take_query;
    logic take_load;

    assign take_query = i_in_valid && i_in_ready && (i_in_action == tgi_pkg::ACT_QUERY);
    assign take_load  = i_in_valid && i_in_ready && (i_in_action == tgi_pkg::ACT_LOAD);

    // A stalled response keeps its value.
    `TGI_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value), "response dropped or changed while stalled")

    // The input is not ready while a taken query is in progress.
    `TGI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, take_query, !i_in_ready ##1 !i_in_ready, "request taken while a query is in progress")

    // A load never blocks the next request.
    `TGI_ASSERT_NEXT(a_load_quick, i_clk, i_rst_n, take_load, i_in_ready, "load held the request channel")

    // A new response only appears as a query completes.
    `TGI_ASSERT_NOW(a_rsp_source, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "response without a query in progress")

endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_action (i_req.action),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_value (o_rsp.interp_value)
);
